// ----- hdl/ppo_pkg.sv -----
package ppo_pkg;

    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int WEIGHT_W = 18;
    localparam int SPOT_W   = 32;
    localparam int IDX_W    = 3;
    localparam int PROD_W   = WEIGHT_W + SPOT_W + 1;
    localparam int BASKET_W = 54;
    localparam int PAYOFF_W = 32;
    localparam int FRAC_W   = 16;
    localparam int NUM_ASSETS_DEFAULT = 8;

    localparam logic [WEIGHT_W-1:0] WEIGHT0_RESET = WEIGHT_W'(65536);
    localparam logic [PAYOFF_W-1:0] PAYOFF_ONE    = PAYOFF_W'(65536);
    localparam logic [PAYOFF_W-1:0] PAYOFF_MAX    = {PAYOFF_W{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_CLOSE,
        ST_DIV,
        ST_ADD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic done;
        logic overflow;
    } div_status_t;

endpackage

// ----- hdl/ppo_regs.sv -----
module ppo_regs
    import ppo_pkg::*;
#(
    parameter int NUM_ASSETS = NUM_ASSETS_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ADDR_W-1:0]          paddr,
    input  logic [DATA_W-1:0]          pwdata,
    output logic [DATA_W-1:0]          prdata,
    input  logic [IDX_W-1:0]           sel,
    output logic signed [WEIGHT_W-1:0] weight
);

    logic [WEIGHT_W-1:0] weight_reg [NUM_ASSETS];
    logic                wr_en;
    logic [IDX_W-1:0]    reg_idx;

    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ASSETS; i++)
            begin
                weight_reg[i] <= (i == 0) ? WEIGHT0_RESET : '0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_ASSETS; i++)
            begin
                if (wr_en && reg_idx == IDX_W'(i))
                begin
                    weight_reg[i] <= pwdata[WEIGHT_W-1:0];
                end
            end
        end
    end

    // Registers past the configured asset count read as zero and weigh zero.
    always_comb
    begin
        prdata = '0;
        weight = '0;
        for (int i = 0; i < NUM_ASSETS; i++)
        begin
            if (reg_idx == IDX_W'(i))
            begin
                prdata = {{(DATA_W-WEIGHT_W){1'b0}}, weight_reg[i]};
            end
            if (sel == IDX_W'(i))
            begin
                weight = $signed(weight_reg[i]);
            end
        end
    end

endmodule

// ----- hdl/ppo_div.sv -----
module ppo_div
    import ppo_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [BASKET_W-1:0] dividend,
    input  logic [BASKET_W-1:0] divisor,
    output logic [PAYOFF_W-1:0] quotient,
    output div_status_t         status
);

    localparam int CNT_W = $clog2(PAYOFF_W);

    logic                busy_reg,  busy_next;
    logic                done_reg,  done_next;
    logic                ovf_reg,   ovf_next;
    logic [CNT_W-1:0]    cnt_reg,   cnt_next;
    logic [BASKET_W-1:0] rem_reg,   rem_next;
    logic [BASKET_W-1:0] den_reg,   den_next;
    logic [PAYOFF_W-1:0] low_reg,   low_next;
    logic [PAYOFF_W-1:0] quo_reg,   quo_next;
    logic [BASKET_W-1:0] trial;
    logic [BASKET_W-1:0] head;

    // The quotient is the dividend scaled by 2^16 over the divisor. The top part
    // of the scaled dividend is the dividend shifted down by 16; if it already
    // reaches the divisor, the integer part is 2^16 or more.
    assign head  = dividend >> FRAC_W;
    assign trial = {rem_reg[BASKET_W-2:0], low_reg[PAYOFF_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            rem_next  = head;
            den_next  = divisor;
            low_next  = {dividend[FRAC_W-1:0], {(PAYOFF_W-FRAC_W){1'b0}}};
            quo_next  = '0;
            cnt_next  = '0;
            ovf_next  = (head >= divisor);
            busy_next = (head < divisor);
            done_next = (head >= divisor);
        end
        else if (busy_reg)
        begin
            if (trial >= den_reg)
            begin
                rem_next = trial - den_reg;
                quo_next = {quo_reg[PAYOFF_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[PAYOFF_W-2:0], 1'b0};
            end
            low_next = {low_reg[PAYOFF_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(PAYOFF_W-1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ovf_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            ovf_reg  <= ovf_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
    end

    assign quotient        = quo_reg;
    assign status.done     = done_reg;
    assign status.overflow = ovf_reg;

endmodule

// ----- hdl/performance_option_payoff_top.sv -----
// A spot that does not close a date takes a multiply step, then an accumulate step.
// A date close adds a close step; when the 32-step divider runs (it skips its steps on
// overflow), an add step follows. A path end adds a step to load the output register,
// waiting while it is still full. A new request is taken only in idle, one at a time.
// Reset (rst_n low, asynchronous) sets weight_0 to 1.0, the other weights to 0,
// the payoff to 1.0, and clears the basket, flags and output valid.
module performance_option_payoff_top
    import ppo_pkg::*;
#(
    parameter int NUM_ASSETS = NUM_ASSETS_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [SPOT_W-1:0]   spot,
    input  logic [IDX_W-1:0]    asset_index,
    input  logic                end_of_date,
    input  logic                end_of_path,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [PAYOFF_W-1:0] payoff_value,
    output logic                divide_fault,
    output logic                saturated
);

    state_t state_reg, state_next;

    logic signed [WEIGHT_W-1:0] weight;
    logic signed [PROD_W-1:0]   prod_reg,    prod_next;
    logic signed [BASKET_W-1:0] basket_reg,  basket_next;
    logic signed [BASKET_W-1:0] prev_reg,    prev_next;
    logic [PAYOFF_W-1:0]        payoff_reg,  payoff_next;
    logic                       first_reg,   first_next;
    logic                       fault_reg,   fault_next;
    logic                       sat_reg,     sat_next;
    logic                       close_reg,   close_next;
    logic                       eop_reg,     eop_next;
    logic                       oval_reg,    oval_next;
    logic [PAYOFF_W-1:0]        opay_reg,    opay_next;
    logic                       ofault_reg,  ofault_next;
    logic                       osat_reg,    osat_next;

    logic                       div_start;
    logic [BASKET_W-1:0]        diff;
    logic [PAYOFF_W-1:0]        quotient;
    div_status_t                div_status;
    logic [PAYOFF_W:0]          pay_sum;

    ppo_regs #(
        .NUM_ASSETS (NUM_ASSETS)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .sel     (asset_index),
        .weight  (weight)
    );

    assign diff = basket_reg - prev_reg;

    ppo_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (diff),
        .divisor  (prev_reg),
        .quotient (quotient),
        .status   (div_status)
    );

    // An overflowing ratio adds 2^32, which always clips.
    assign pay_sum = {1'b0, payoff_reg}
                   + (div_status.overflow ? {1'b1, {PAYOFF_W{1'b0}}} : {1'b0, quotient});

    always_comb
    begin
        state_next  = state_reg;
        prod_next   = prod_reg;
        basket_next = basket_reg;
        prev_next   = prev_reg;
        payoff_next = payoff_reg;
        first_next  = first_reg;
        fault_next  = fault_reg;
        sat_next    = sat_reg;
        close_next  = close_reg;
        eop_next    = eop_reg;
        oval_next   = oval_reg;
        opay_next   = opay_reg;
        ofault_next = ofault_reg;
        osat_next   = osat_reg;
        div_start   = 1'b0;
        in_ready    = 1'b0;

        if (oval_reg && out_ready)
        begin
            oval_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    prod_next  = weight * $signed({1'b0, spot});
                    close_next = end_of_date | end_of_path;
                    eop_next   = end_of_path;
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                basket_next = basket_reg
                            + {{(BASKET_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
                state_next  = close_reg ? ST_CLOSE : ST_IDLE;
            end
            ST_CLOSE:
            begin
                if (!first_reg && !prev_reg[BASKET_W-1] && prev_reg != '0
                    && basket_reg > prev_reg)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    if (first_reg)
                    begin
                        first_next = 1'b0;
                    end
                    else if (prev_reg[BASKET_W-1] || prev_reg == '0)
                    begin
                        fault_next = 1'b1;
                    end
                    prev_next   = basket_reg;
                    basket_next = '0;
                    state_next  = eop_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                if (pay_sum[PAYOFF_W])
                begin
                    payoff_next = PAYOFF_MAX;
                    sat_next    = 1'b1;
                end
                else
                begin
                    payoff_next = pay_sum[PAYOFF_W-1:0];
                end
                prev_next   = basket_reg;
                basket_next = '0;
                state_next  = eop_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                // Wait until the output register is free, then start a new path.
                if (!oval_reg || out_ready)
                begin
                    oval_next   = 1'b1;
                    opay_next   = payoff_reg;
                    ofault_next = fault_reg;
                    osat_next   = sat_reg;
                    basket_next = '0;
                    prev_next   = '0;
                    payoff_next = PAYOFF_ONE;
                    first_next  = 1'b1;
                    fault_next  = 1'b0;
                    sat_next    = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            basket_reg <= '0;
            prev_reg   <= '0;
            payoff_reg <= PAYOFF_ONE;
            first_reg  <= 1'b1;
            fault_reg  <= 1'b0;
            sat_reg    <= 1'b0;
            close_reg  <= 1'b0;
            eop_reg    <= 1'b0;
            oval_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            basket_reg <= basket_next;
            prev_reg   <= prev_next;
            payoff_reg <= payoff_next;
            first_reg  <= first_next;
            fault_reg  <= fault_next;
            sat_reg    <= sat_next;
            close_reg  <= close_next;
            eop_reg    <= eop_next;
            oval_reg   <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        opay_reg   <= opay_next;
        ofault_reg <= ofault_next;
        osat_reg   <= osat_next;
    end

    assign pready       = 1'b1;
    assign out_valid    = oval_reg;
    assign payoff_value = opay_reg;
    assign divide_fault = ofault_reg;
    assign saturated    = osat_reg;

endmodule
